### rtl/sdc_pkg.sv
`timescale 1ns / 1ps
package sdc_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [15:0] START_PULSE_RESET    = 16'd500;
   localparam logic [15:0] COAST_RESET          = 16'd1000;
   localparam logic [15:0] ERROR_RECOVER_RESET  = 16'd5000;
   localparam logic [9:0]  BLINK_UNIT_RESET     = 10'd100;
   localparam logic [15:0] COLD_START_MS        = 16'd2000;

   typedef enum logic [1:0] {
      CSR_START_PULSE   = 2'd0,
      CSR_COAST         = 2'd1,
      CSR_ERROR_RECOVER = 2'd2,
      CSR_BLINK_UNIT    = 2'd3
   } csr_index_type;

   typedef enum logic [9:0] {
      MODE_ERROR     = 10'b00_0000_0001,
      MODE_COLD      = 10'b00_0000_0010,
      MODE_ESTOP     = 10'b00_0000_0100,
      MODE_READY     = 10'b00_0000_1000,
      MODE_FWD_START = 10'b00_0001_0000,
      MODE_FWD_RUN   = 10'b00_0010_0000,
      MODE_FWD_COAST = 10'b00_0100_0000,
      MODE_REV_START = 10'b00_1000_0000,
      MODE_REV_RUN   = 10'b01_0000_0000,
      MODE_REV_COAST = 10'b10_0000_0000
   } mode_type;

   typedef struct packed {
      logic tick;
      logic light_req;
      logic fwd_req;
      logic rev_req;
      logic estop_clear;
   } req_type;

   typedef struct packed {
      logic       light_drive;
      logic       inhibit_drive;
      logic       start_drive;
      logic       direction_drive;
      logic       status_led;
      logic [3:0] mode_code;
   } rsp_type;

   typedef struct packed {
      logic [15:0] start_pulse_ms;
      logic [15:0] coast_ms;
      logic [15:0] error_recover_ms;
      logic [9:0]  blink_unit_ms;
   } cfg_type;

   typedef struct packed {
      mode_type mode_cur;
      mode_type mode_nxt;
      logic     light_drive;
      logic     inhibit_drive;
      logic     start_drive;
      logic     direction_drive;
   } ctrl_status_type;

   function automatic logic [3:0] mode_to_code(input mode_type m);
      logic [3:0] code;
      case (m)
         MODE_ERROR:     code = 4'd0;
         MODE_COLD:      code = 4'd1;
         MODE_ESTOP:     code = 4'd2;
         MODE_READY:     code = 4'd3;
         MODE_FWD_START: code = 4'd4;
         MODE_FWD_RUN:   code = 4'd5;
         MODE_FWD_COAST: code = 4'd6;
         MODE_REV_START: code = 4'd7;
         MODE_REV_RUN:   code = 4'd8;
         MODE_REV_COAST: code = 4'd9;
         default:        code = 4'd0;
      endcase
      return code;
   endfunction

   // upper nibble: symbol count, lower nibble: dash mask, first symbol in bit 0
   function automatic logic [7:0] morse_entry(input mode_type m);
      logic [7:0] e;
      case (m)
         MODE_ERROR:     e = 8'h49;
         MODE_COLD:      e = 8'h30;
         MODE_ESTOP:     e = 8'h11;
         MODE_READY:     e = 8'h32;
         MODE_FWD_START: e = 8'h22;
         MODE_FWD_RUN:   e = 8'h41;
         MODE_FWD_COAST: e = 8'h43;
         MODE_REV_START: e = 8'h20;
         MODE_REV_RUN:   e = 8'h4e;
         MODE_REV_COAST: e = 8'h35;
         default:        e = 8'h00;
      endcase
      return e;
   endfunction

endpackage

### rtl/sdc_csr.sv
`timescale 1ns / 1ps
module sdc_csr
   import sdc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index  = csr_index_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            CSR_START_PULSE:   cfg_in.start_pulse_ms   = pwdata[15:0];
            CSR_COAST:         cfg_in.coast_ms         = pwdata[15:0];
            CSR_ERROR_RECOVER: cfg_in.error_recover_ms = pwdata[15:0];
            CSR_BLINK_UNIT:    cfg_in.blink_unit_ms    = pwdata[9:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_START_PULSE:   prdata = {16'd0, cfg_ff.start_pulse_ms};
         CSR_COAST:         prdata = {16'd0, cfg_ff.coast_ms};
         CSR_ERROR_RECOVER: prdata = {16'd0, cfg_ff.error_recover_ms};
         CSR_BLINK_UNIT:    prdata = {22'd0, cfg_ff.blink_unit_ms};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_pulse_ms   <= START_PULSE_RESET;
         cfg_ff.coast_ms         <= COAST_RESET;
         cfg_ff.error_recover_ms <= ERROR_RECOVER_RESET;
         cfg_ff.blink_unit_ms    <= BLINK_UNIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/sdc_ctrl.sv
`timescale 1ns / 1ps
module sdc_ctrl
   import sdc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  req_type         item,
   input  cfg_type         cfg,
   output ctrl_status_type status
);

   mode_type    mode_ff, mode_in;
   logic [15:0] countdown_ff, countdown_in;
   logic        expired_ff, expired_in;
   logic        dir_ff, dir_in;
   logic [15:0] cd_dec;
   logic        exp_dec;
   logic        done;
   logic        both;
   logic        arm;
   logic [15:0] arm_val;
   logic        ok, fwd, rev;

   assign ok   = item.estop_clear;
   assign fwd  = item.fwd_req;
   assign rev  = item.rev_req;
   assign both = fwd && rev;

   always_comb begin
      cd_dec  = countdown_ff;
      exp_dec = expired_ff;
      if (item.tick && (countdown_ff != 16'd0)) begin
         cd_dec = countdown_ff - 16'd1;
         if (countdown_ff == 16'd1) begin
            exp_dec = 1'b1;
         end
      end
   end

   assign done = exp_dec;

   always_comb begin
      mode_in = mode_ff;
      arm     = 1'b0;
      arm_val = 16'd0;
      case (mode_ff)
         MODE_ERROR: begin
            if (both) begin
               mode_in = MODE_ERROR; arm = 1'b1; arm_val = cfg.error_recover_ms;
            end else if (done) begin
               mode_in = MODE_ESTOP; arm = 1'b1;
            end
         end
         MODE_COLD: begin
            if (done) begin
               mode_in = MODE_ESTOP; arm = 1'b1;
            end
         end
         MODE_ESTOP: begin
            if (both) begin
               mode_in = MODE_ERROR; arm = 1'b1; arm_val = cfg.error_recover_ms;
            end else if (ok) begin
               mode_in = MODE_READY; arm = 1'b1;
            end
         end
         MODE_READY: begin
            if (both) begin
               mode_in = MODE_ERROR; arm = 1'b1; arm_val = cfg.error_recover_ms;
            end else if (!ok) begin
               mode_in = MODE_ESTOP; arm = 1'b1;
            end else if (fwd) begin
               mode_in = MODE_FWD_START; arm = 1'b1; arm_val = cfg.start_pulse_ms;
            end else if (rev) begin
               mode_in = MODE_REV_START; arm = 1'b1; arm_val = cfg.start_pulse_ms;
            end
         end
         MODE_FWD_START, MODE_FWD_RUN: begin
            if (rev) begin
               mode_in = MODE_ERROR; arm = 1'b1; arm_val = cfg.error_recover_ms;
            end else if (!ok || !fwd) begin
               mode_in = MODE_FWD_COAST; arm = 1'b1; arm_val = cfg.coast_ms;
            end else if ((mode_ff == MODE_FWD_START) && done) begin
               mode_in = MODE_FWD_RUN; arm = 1'b1;
            end
         end
         MODE_REV_START, MODE_REV_RUN: begin
            if (fwd) begin
               mode_in = MODE_ERROR; arm = 1'b1; arm_val = cfg.error_recover_ms;
            end else if (!ok || !rev) begin
               mode_in = MODE_REV_COAST; arm = 1'b1; arm_val = cfg.coast_ms;
            end else if ((mode_ff == MODE_REV_START) && done) begin
               mode_in = MODE_REV_RUN; arm = 1'b1;
            end
         end
         MODE_FWD_COAST: begin
            if (rev) begin
               mode_in = MODE_ERROR; arm = 1'b1; arm_val = cfg.error_recover_ms;
            end else if (ok && fwd) begin
               mode_in = MODE_FWD_START; arm = 1'b1; arm_val = cfg.start_pulse_ms;
            end else if (done) begin
               mode_in = ok ? MODE_READY : MODE_ESTOP; arm = 1'b1;
            end
         end
         MODE_REV_COAST: begin
            if (fwd) begin
               mode_in = MODE_ERROR; arm = 1'b1; arm_val = cfg.error_recover_ms;
            end else if (ok && rev) begin
               mode_in = MODE_REV_START; arm = 1'b1; arm_val = cfg.start_pulse_ms;
            end else if (done) begin
               mode_in = ok ? MODE_READY : MODE_ESTOP; arm = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_ERROR; arm = 1'b1; arm_val = cfg.error_recover_ms;
         end
      endcase
   end

   assign countdown_in = arm ? arm_val : cd_dec;
   assign expired_in   = arm ? 1'b0 : exp_dec;

   always_comb begin
      dir_in = dir_ff;
      if (mode_in != MODE_ERROR) begin
         dir_in = (mode_in == MODE_REV_START) || (mode_in == MODE_REV_RUN) ||
                  (mode_in == MODE_REV_COAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_COLD;
         countdown_ff <= COLD_START_MS;
         expired_ff   <= 1'b0;
         dir_ff       <= 1'b0;
      end else if (step) begin
         mode_ff      <= mode_in;
         countdown_ff <= countdown_in;
         expired_ff   <= expired_in;
         dir_ff       <= dir_in;
      end
   end

   always_comb begin
      status.mode_cur        = mode_ff;
      status.mode_nxt        = mode_in;
      status.light_drive     = item.light_req && (mode_in != MODE_ERROR) &&
                               (mode_in != MODE_COLD);
      status.inhibit_drive   = (mode_in == MODE_FWD_START) || (mode_in == MODE_FWD_RUN) ||
                               (mode_in == MODE_REV_START) || (mode_in == MODE_REV_RUN);
      status.start_drive     = (mode_in == MODE_FWD_START) || (mode_in == MODE_REV_START);
      status.direction_drive = dir_in;
   end

   a_start_loads_pulse: assert property (@(posedge clock) disable iff (reset)
      step && (mode_ff == MODE_READY) && (mode_in == MODE_FWD_START)
      |=> countdown_ff == $past(cfg.start_pulse_ms) && !expired_ff)
      else $error("start pulse countdown not loaded");

   a_error_loads_recover: assert property (@(posedge clock) disable iff (reset)
      step && (mode_ff != MODE_ERROR) && (mode_in == MODE_ERROR)
      |=> countdown_ff == $past(cfg.error_recover_ms))
      else $error("error recovery countdown not loaded");

   a_run_idle_countdown: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_FWD_RUN) || (mode_ff == MODE_REV_RUN) |-> countdown_ff == 16'd0)
      else $error("countdown running in a run state");

endmodule

### rtl/sdc_blink.sv
`timescale 1ns / 1ps
module sdc_blink
   import sdc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic            tick,
   input  logic [9:0]      blink_unit_ms,
   input  ctrl_status_type status,
   output logic            status_led
);

   logic [3:0]  phase_ff, phase_in;
   logic [12:0] remaining_ff, remaining_in;
   logic        armed_ff;
   logic [7:0]  entry;
   logic [4:0]  pattern_len;
   logic [12:0] unit1, unit3, unit7;
   logic [12:0] rem_dec;
   logic [3:0]  phase_adv;
   logic [3:0]  phase_m1;
   logic [1:0]  sym_idx;
   logic [12:0] adv_time;

   assign entry       = morse_entry(status.mode_nxt);
   assign pattern_len = {entry[7:4], 1'b1};
   assign unit1       = {3'd0, blink_unit_ms};
   assign unit3       = (unit1 << 1) + unit1;
   assign unit7       = (unit1 << 3) - unit1;

   assign rem_dec   = (tick && (remaining_ff != 13'd0)) ? remaining_ff - 13'd1 : remaining_ff;
   assign phase_adv = (({1'b0, phase_ff} + 5'd1) == pattern_len) ? 4'd0 : phase_ff + 4'd1;
   assign phase_m1  = phase_adv - 4'd1;
   assign sym_idx   = phase_m1[2:1];

   always_comb begin
      if (phase_adv == 4'd0) begin
         adv_time = unit7;
      end else if (phase_adv[0]) begin
         adv_time = entry[sym_idx] ? unit3 : unit1;
      end else begin
         adv_time = unit1;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = rem_dec;
      if (!armed_ff || (status.mode_cur != status.mode_nxt)) begin
         phase_in     = 4'd0;
         remaining_in = unit7;
      end else if (rem_dec == 13'd0) begin
         phase_in     = phase_adv;
         remaining_in = adv_time;
      end
   end

   assign status_led = phase_in[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 4'd0;
         remaining_ff <= 13'd0;
         armed_ff     <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         armed_ff     <= 1'b1;
      end
   end

   a_phase_in_pattern: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= 4'd8)
      else $error("blink phase beyond longest pattern");

   a_mode_change_restarts: assert property (@(posedge clock) disable iff (reset)
      step && (status.mode_cur != status.mode_nxt) |=> phase_ff == 4'd0)
      else $error("blink pattern not restarted on mode change");

   a_unarmed_idle: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> (phase_ff == 4'd0) && (remaining_ff == 13'd0))
      else $error("blink state moved before the first beat");

endmodule

### rtl/spindle_direction_controller_unit.sv
`timescale 1ns / 1ps
// Spindle direction controller with Morse status LED.
// req channel: one beat per switch sample (tick, light, forward, reverse,
// e-stop ok). rsp channel: one beat per sample with light, inhibit, start,
// direction, status LED and the current mode code.
// Timing registers are written over the APB port (start pulse, coast,
// error recovery, blink unit); write only while no beat is in flight.
// A beat accepted is held in the input register, then passed into the result
// register and presented on rsp from then on. Throughput: one beat per cycle
// while rsp is not stalled, set by the single pass from the input register
// through the mode and blink logic into the result register.
// Stall: a stalled rsp beat holds; one further req beat is taken into the
// input register, then req_stall rises until the result is taken.
// Reset: mode goes to cold start with a 2000 ms countdown, the blink
// pattern is rebuilt on the first beat, timing registers take their
// defaults and both channels come up empty.
module spindle_direction_controller_unit
   import sdc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type         cfg;
   ctrl_status_type status;
   logic            in_valid_ff, in_valid_in;
   req_type         in_data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, result;
   logic            advance;
   logic            step;
   logic            accept;
   logic            status_led;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && rsp_stall);

   sdc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sdc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_data_ff),
      .cfg    (cfg),
      .status (status)
   );

   sdc_blink u_blink (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .tick          (in_data_ff.tick),
      .blink_unit_ms (cfg.blink_unit_ms),
      .status        (status),
      .status_led    (status_led)
   );

   always_comb begin
      result.light_drive     = status.light_drive;
      result.inhibit_drive   = status.inhibit_drive;
      result.start_drive     = status.start_drive;
      result.direction_drive = status.direction_drive;
      result.status_led      = status_led;
      result.mode_code       = mode_to_code(status.mode_nxt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("req stalled while a stage is free");

   a_step_fills_output: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed beat lost");

   a_no_result_from_nothing: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !in_valid_ff |=> !rsp_valid_ff)
      else $error("result beat without an input beat");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
module tb;
   import sdc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [3:0] MC_ERROR     = 4'd0;
   localparam logic [3:0] MC_COLD      = 4'd1;
   localparam logic [3:0] MC_ESTOP     = 4'd2;
   localparam logic [3:0] MC_READY     = 4'd3;
   localparam logic [3:0] MC_FWD_START = 4'd4;
   localparam logic [3:0] MC_FWD_RUN   = 4'd5;
   localparam logic [3:0] MC_FWD_COAST = 4'd6;
   localparam logic [3:0] MC_REV_START = 4'd7;
   localparam logic [3:0] MC_REV_RUN   = 4'd8;
   localparam logic [3:0] MC_REV_COAST = 4'd9;

   // per mode code: symbol count in [7:4], dash mask in [3:0] (first symbol in bit 0)
   localparam logic [79:0] MORSE_BITS = {8'h35, 8'h4e, 8'h20, 8'h43, 8'h41,
                                         8'h22, 8'h32, 8'h11, 8'h30, 8'h49};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   spindle_direction_controller_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // controller shadow
   logic [15:0] cfg_pulse = START_PULSE_RESET;
   logic [15:0] cfg_coast = COAST_RESET;
   logic [15:0] cfg_recover = ERROR_RECOVER_RESET;
   logic [9:0]  cfg_unit = BLINK_UNIT_RESET;
   logic [3:0]  mode_q = MC_COLD;
   logic [15:0] timer_q = COLD_START_MS;
   logic        timer_done_q = 1'b0;
   logic        dir_hold_q = 1'b0;
   logic [3:0]  blink_phase_q = '0;
   logic [12:0] blink_left_q = '0;
   logic        blink_armed_q = 1'b0;

   rsp_type     drive_q[$];
   rsp_type     want;
   int          mismatches = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          hold_left = 0;
   logic        hold_kick = 1'b0;
   logic        hold_seen = 1'b0;
   int          profile_sel = 0;
   int          quiet;
   logic        op_fwd = 1'b0;
   logic        op_rev = 1'b0;

   task automatic enter_mode(input logic [3:0] m, input logic [15:0] ms);
      mode_q = m;
      timer_q = ms;
      timer_done_q = 1'b0;
   endtask

   function automatic logic [12:0] phase_span(input logic [3:0] m, input logic [3:0] ph);
      logic [7:0]  letter;
      logic [12:0] span;
      int          i;
      letter = MORSE_BITS[m*8 +: 8];
      i = ((ph - 1) >> 1) & 3;
      if (ph == 0) span = 13'(7 * cfg_unit);
      else if (ph[0] && letter[i]) span = 13'(3 * cfg_unit);
      else span = {3'd0, cfg_unit};
      return span;
   endfunction

   task automatic predict_drive(input req_type s, output rsp_type r);
      logic       both, done, is_rev, other, mine;
      logic [3:0] prev, base;
      logic [7:0] letter;
      both = s.fwd_req & s.rev_req;
      prev = mode_q;
      if (s.tick && timer_q != 0) begin
         timer_q = timer_q - 16'd1;
         if (timer_q == 0) timer_done_q = 1'b1;
      end
      done = timer_done_q;
      is_rev = (mode_q >= MC_REV_START);
      other = is_rev ? s.fwd_req : s.rev_req;
      mine = is_rev ? s.rev_req : s.fwd_req;
      base = is_rev ? MC_REV_START : MC_FWD_START;
      case (mode_q)
         MC_ERROR: begin
            if (both) enter_mode(MC_ERROR, cfg_recover);
            else if (done) enter_mode(MC_ESTOP, 16'd0);
         end
         MC_COLD: begin
            if (done) enter_mode(MC_ESTOP, 16'd0);
         end
         MC_ESTOP: begin
            if (both) enter_mode(MC_ERROR, cfg_recover);
            else if (s.estop_clear) enter_mode(MC_READY, 16'd0);
         end
         MC_READY: begin
            if (both) enter_mode(MC_ERROR, cfg_recover);
            else if (!s.estop_clear) enter_mode(MC_ESTOP, 16'd0);
            else if (s.fwd_req) enter_mode(MC_FWD_START, cfg_pulse);
            else if (s.rev_req) enter_mode(MC_REV_START, cfg_pulse);
         end
         MC_FWD_START, MC_FWD_RUN, MC_REV_START, MC_REV_RUN: begin
            if (other) enter_mode(MC_ERROR, cfg_recover);
            else if (!s.estop_clear || !mine) enter_mode(base + 4'd2, cfg_coast);
            else if (mode_q == base && done) enter_mode(base + 4'd1, 16'd0);
         end
         MC_FWD_COAST, MC_REV_COAST: begin
            if (other) enter_mode(MC_ERROR, cfg_recover);
            else if (s.estop_clear && mine) enter_mode(base, cfg_pulse);
            else if (done) enter_mode(s.estop_clear ? MC_READY : MC_ESTOP, 16'd0);
         end
         default: enter_mode(MC_ERROR, cfg_recover);
      endcase

      // blink pattern restarts on every mode change
      letter = MORSE_BITS[mode_q*8 +: 8];
      if (!blink_armed_q || prev != mode_q) begin
         blink_armed_q = 1'b1;
         blink_phase_q = '0;
         blink_left_q = phase_span(mode_q, 4'd0);
      end else begin
         if (s.tick && blink_left_q != 0) blink_left_q = blink_left_q - 13'd1;
         if (blink_left_q == 0) begin
            if (blink_phase_q + 1 >= 1 + 2 * letter[7:4]) blink_phase_q = '0;
            else blink_phase_q = blink_phase_q + 4'd1;
            blink_left_q = phase_span(mode_q, blink_phase_q);
         end
      end

      r = '0;
      if (mode_q != MC_ERROR) begin
         dir_hold_q = (mode_q >= MC_REV_START);
         if (mode_q != MC_COLD) r.light_drive = s.light_req;
      end
      r.direction_drive = dir_hold_q;
      r.inhibit_drive = (mode_q == MC_FWD_START || mode_q == MC_FWD_RUN ||
                         mode_q == MC_REV_START || mode_q == MC_REV_RUN);
      r.start_drive = (mode_q == MC_FWD_START || mode_q == MC_REV_START);
      r.status_led = blink_phase_q[0];
      r.mode_code = mode_q;
   endtask

   task automatic send_sample(input req_type s);
      rsp_type r;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (req_stall);
      predict_drive(s, r);
      drive_q.push_back(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (drive_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         CSR_START_PULSE:   cfg_pulse = value[15:0];
         CSR_COAST:         cfg_coast = value[15:0];
         CSR_ERROR_RECOVER: cfg_recover = value[15:0];
         default:           cfg_unit = value[9:0];
      endcase
   endtask

   task automatic program_timers(input logic [15:0] pulse, input logic [15:0] coast,
                                 input logic [15:0] recover, input logic [9:0] unit);
      drain();
      write_reg(CSR_START_PULSE, {16'd0, pulse});
      write_reg(CSR_COAST, {16'd0, coast});
      write_reg(CSR_ERROR_RECOVER, {16'd0, recover});
      write_reg(CSR_BLINK_UNIT, {22'd0, unit});
   endtask

   // operator holding a direction for a while, with e-stop drops and clashes as noise
   function automatic req_type operator_sample();
      req_type s;
      if ($urandom_range(11) == 0) begin
         case ($urandom_range(2))
            0:       begin op_fwd = 1'b0; op_rev = 1'b0; end
            1:       begin op_fwd = 1'b1; op_rev = 1'b0; end
            default: begin op_fwd = 1'b0; op_rev = 1'b1; end
         endcase
      end
      s.tick = ($urandom_range(9) < 7);
      s.light_req = 1'($urandom_range(1));
      s.fwd_req = op_fwd;
      s.rev_req = op_rev;
      s.estop_clear = ($urandom_range(19) != 0);
      if ($urandom_range(24) == 0) begin
         s.fwd_req = 1'b1;
         s.rev_req = 1'b1;
      end else if ($urandom_range(24) == 0) begin
         s.fwd_req = 1'($urandom_range(1));
         s.rev_req = 1'($urandom_range(1));
      end
      return s;
   endfunction

   task automatic run_operator(input int beats);
      for (int i = 0; i < beats; i++) begin
         if (i % 50 == 0) begin
            case (profile_sel % 4)
               0:       begin idle_pct = 0;  stall_pct = 0;  end
               1:       begin idle_pct = 59; stall_pct = 0;  end
               2:       begin idle_pct = 0;  stall_pct = 59; end
               default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            profile_sel++;
         end
         send_sample(operator_sample());
      end
   endtask

   // cold start only ends after its full countdown, so every sample carries a tick
   task automatic test_cold_start();
      logic [4:0] bits;
      req_type    s;
      idle_pct = 17;
      stall_pct = 17;
      while (mode_q == MC_COLD) begin
         bits = 5'($urandom_range(31));
         s = bits;
         s.tick = 1'b1;
         send_sample(s);
      end
   endtask

   task automatic test_directed();
      program_timers(16'd3, 16'd3, 16'd3, 10'd1);
      idle_pct = 0;
      stall_pct = 0;
      // bit order: tick, light, fwd, rev, e-stop ok
      send_sample(5'b01000);
      send_sample(5'b10110);
      send_sample(5'b11111);
      repeat (3) send_sample(5'b10001);
      send_sample(5'b01001);
      send_sample(5'b00000);
      send_sample(5'b01001);
      send_sample(5'b01101);
      repeat (3) send_sample(5'b11101);
      send_sample(5'b01100);
      send_sample(5'b01101);
      send_sample(5'b11001);
      repeat (3) send_sample(5'b11001);
      send_sample(5'b01011);
      repeat (3) send_sample(5'b10011);
      send_sample(5'b00111);
   endtask

   task automatic test_timer_extremes();
      for (int k = 0; k < 4; k++) begin
         case (k)
            0: program_timers(16'd0, 16'd0, 16'd0, 10'd0);
            1: program_timers(16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1023);
            2: program_timers(16'd1, 16'd1, 16'd1, 10'd1);
            default: program_timers(START_PULSE_RESET, COAST_RESET,
                                    ERROR_RECOVER_RESET, BLINK_UNIT_RESET);
         endcase
         run_operator(60);
      end
   endtask

   task automatic test_back_pressure();
      program_timers(16'd2, 16'd2, 16'd2, 10'd1);
      idle_pct = 0;
      stall_pct = 0;
      hold_kick = ~hold_kick;
      repeat (40) send_sample(operator_sample());
   endtask

   task automatic test_random_timers();
      repeat (5) begin
         program_timers(16'($urandom_range(12)), 16'($urandom_range(12)),
                        16'($urandom_range(12)), 10'($urandom_range(4, 1)));
         run_operator(60);
      end
   endtask

   // result side: random stall, long hold on request, and the compare
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", rsp_data);
         end else begin
            want = drive_q.pop_front();
            if (rsp_data.light_drive !== want.light_drive ||
                rsp_data.inhibit_drive !== want.inhibit_drive ||
                rsp_data.start_drive !== want.start_drive ||
                rsp_data.direction_drive !== want.direction_drive ||
                rsp_data.status_led !== want.status_led ||
                rsp_data.mode_code !== want.mode_code) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp light %b inh %b start %b dir %b led %b mode %0d, ",
                           want.light_drive, want.inhibit_drive, want.start_drive,
                           want.direction_drive, want.status_led, want.mode_code,
                           "got light %b inh %b start %b dir %b led %b mode %0d",
                           rsp_data.light_drive, rsp_data.inhibit_drive,
                           rsp_data.start_drive, rsp_data.direction_drive,
                           rsp_data.status_led, rsp_data.mode_code);
            end
         end
      end
      if (hold_kick != hold_seen) begin
         hold_seen = hold_kick;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_cold_start();
      test_directed();
      test_timer_extremes();
      test_back_pressure();
      test_random_timers();
      drain();
      if (mismatches == 0 && drive_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
